// ===== rtl/core/sarct_pkg.sv =====
// Types and constants shared by the countdown timer modules.
`timescale 1ns / 1ps

package sarct_pkg;

    localparam int KNOB_W = 12;
    localparam int TIME_W = 6;
    localparam int MODE_W = 2;
    localparam int PROD_W = 18;

    localparam logic [KNOB_W-1:0] JITTER_RESET = 12'd50;
    localparam logic [PROD_W-1:0] KNOB_SCALE   = 18'd60;
    localparam logic [12:0]       MIN_DIVISOR  = 13'd4095;
    localparam logic [7:0]        SEC_LIMIT    = 8'd60;
    localparam logic [TIME_W-1:0] SEC_WRAP     = 6'd59;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_MIN = 2'd0,
        MODE_SET_SEC = 2'd1,
        MODE_RUN     = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] minutes;
        logic [TIME_W-1:0] seconds;
        logic              running;
        logic              prev_button;
        logic [KNOB_W-1:0] prev_knob;
    } state_t;

endpackage

// ===== rtl/core/set_and_run_countdown_timer_top.sv =====
// Top level of the minute/second countdown timer.
//
//  channel | signals                                   | dir | beat
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_valid, in_ready, button_level, knob_sample | in  | one one-second tick
//  out     | out_valid, out_ready, minutes_left ...      | out | one result per tick
//  cfg     | cfg_valid, cfg_ready, cfg_data            | in  | jitter threshold write
//
// A tick beat lands in an input register, is processed by the step logic and lands
// in the result register; one beat a cycle while out_ready does not stall the output.
// The input register keeps accepting while a result waits, up to one held beat.
// cfg is always ready; reset sets threshold 50 and clears valid flags, mode and time.
`timescale 1ns / 1ps

module set_and_run_countdown_timer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         button_level,
    input  logic [sarct_pkg::KNOB_W-1:0] knob_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sarct_pkg::TIME_W-1:0] minutes_left,
    output logic [sarct_pkg::TIME_W-1:0] seconds_left,
    output logic [sarct_pkg::MODE_W-1:0] timer_mode,
    output logic                         counting,
    output logic                         display_update,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sarct_pkg::KNOB_W-1:0] cfg_data
);
    import sarct_pkg::*;

    logic              hold_valid_reg;
    logic              hold_button_reg;
    logic [KNOB_W-1:0] hold_knob_reg;
    logic [KNOB_W-1:0] jitter_reg;
    state_t            state_reg;
    state_t            state_next;
    logic              upd_next;
    logic              out_valid_reg;
    logic [TIME_W-1:0] minutes_reg;
    logic [TIME_W-1:0] seconds_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              counting_reg;
    logic              update_reg;
    logic [TIME_W-1:0] knob_minutes;
    logic [TIME_W-1:0] knob_seconds;
    logic              advance;

    assign advance   = hold_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~hold_valid_reg | advance;
    assign cfg_ready = 1'b1;

    sarct_scale u_scale (
        .knob         (hold_knob_reg),
        .knob_minutes (knob_minutes),
        .knob_seconds (knob_seconds)
    );

    sarct_step u_step (
        .cur          (state_reg),
        .button       (hold_button_reg),
        .knob         (hold_knob_reg),
        .jitter       (jitter_reg),
        .knob_minutes (knob_minutes),
        .knob_seconds (knob_seconds),
        .nxt          (state_next),
        .upd          (upd_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_button_reg <= button_level;
            hold_knob_reg   <= knob_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_reg <= JITTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            jitter_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_SET_MIN;
            state_reg.minutes     <= '0;
            state_reg.seconds     <= '0;
            state_reg.running     <= 1'b0;
            state_reg.prev_button <= 1'b1;
            state_reg.prev_knob   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            minutes_reg  <= state_next.minutes;
            seconds_reg  <= state_next.seconds;
            mode_reg     <= state_next.mode;
            counting_reg <= state_next.running;
            update_reg   <= upd_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign minutes_left   = minutes_reg;
    assign seconds_left   = seconds_reg;
    assign timer_mode     = mode_reg;
    assign counting       = counting_reg;
    assign display_update = update_reg;

    a_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.running |-> state_reg.mode == MODE_RUN)
        else $error("count active outside running mode");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.minutes <= TIME_W'(SEC_LIMIT) && state_reg.seconds <= TIME_W'(SEC_LIMIT))
        else $error("time value above sixty");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !advance |=> hold_valid_reg && $stable(hold_knob_reg))
        else $error("held tick lost while stalled");

endmodule

// ===== rtl/core/sarct_scale.sv =====
// Knob sample scaling into minutes (x60/4095) and saturated seconds (x60/1024).
`timescale 1ns / 1ps

module sarct_scale (
    input  logic [sarct_pkg::KNOB_W-1:0] knob,
    output logic [sarct_pkg::TIME_W-1:0] knob_minutes,
    output logic [sarct_pkg::TIME_W-1:0] knob_seconds
);
    import sarct_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [TIME_W-1:0] quot_lo;
    logic [12:0]       rem;
    logic [7:0]        sec_raw;

    // x/4095 is x/4096 or one more; the remainder decides
    assign prod     = PROD_W'(knob) * KNOB_SCALE;
    assign quot_lo  = prod[PROD_W-1:12];
    assign rem      = {1'b0, prod[11:0]} + 13'(quot_lo);
    assign knob_minutes = quot_lo + TIME_W'(rem >= MIN_DIVISOR);

    assign sec_raw  = prod[PROD_W-1:10];
    assign knob_seconds = (sec_raw > SEC_LIMIT) ? TIME_W'(SEC_LIMIT) : sec_raw[TIME_W-1:0];

endmodule

// ===== rtl/core/sarct_step.sv =====
// Per-tick state update: button, knob, then countdown.
`timescale 1ns / 1ps

module sarct_step (
    input  sarct_pkg::state_t            cur,
    input  logic                         button,
    input  logic [sarct_pkg::KNOB_W-1:0] knob,
    input  logic [sarct_pkg::KNOB_W-1:0] jitter,
    input  logic [sarct_pkg::TIME_W-1:0] knob_minutes,
    input  logic [sarct_pkg::TIME_W-1:0] knob_seconds,
    output sarct_pkg::state_t            nxt,
    output logic                         upd
);
    import sarct_pkg::*;

    logic              press;
    logic [KNOB_W-1:0] diff;

    assign press = button & ~cur.prev_button;
    assign diff  = (knob >= cur.prev_knob) ? (knob - cur.prev_knob) : (cur.prev_knob - knob);

    always_comb
    begin
        nxt = cur;
        upd = 1'b0;

        if (press)
        begin
            unique case (cur.mode)
                MODE_SET_MIN: nxt.mode = MODE_SET_SEC;
                MODE_SET_SEC:
                begin
                    nxt.mode    = MODE_RUN;
                    nxt.running = 1'b1;
                end
                default: nxt.running = ~cur.running;
            endcase
            upd = 1'b1;
        end

        if (diff > jitter)
        begin
            unique case (nxt.mode)
                MODE_SET_MIN: nxt.minutes = knob_minutes;
                MODE_SET_SEC: nxt.seconds = knob_seconds;
                default: ;
            endcase
            nxt.prev_knob = knob;
            upd = 1'b1;
        end

        if (nxt.running)
        begin
            priority if (nxt.seconds != '0)
            begin
                nxt.seconds = nxt.seconds - TIME_W'(1);
            end
            else if (nxt.minutes != '0)
            begin
                nxt.minutes = nxt.minutes - TIME_W'(1);
                nxt.seconds = SEC_WRAP;
            end
            else
            begin
                nxt.running = 1'b0;
                nxt.mode    = MODE_SET_MIN;
            end
            upd = 1'b1;
        end

        nxt.prev_button = button;
    end

endmodule

// ===== verif/set_and_run_countdown_timer_checker.sv =====
// Checker for the countdown timer: predicts every result beat from the accepted ticks and compares.
`timescale 1ns / 1ps

module set_and_run_countdown_timer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         button_level,
    input  logic [sarct_pkg::KNOB_W-1:0] knob_sample,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [sarct_pkg::TIME_W-1:0] minutes_left,
    input  logic [sarct_pkg::TIME_W-1:0] seconds_left,
    input  logic [sarct_pkg::MODE_W-1:0] timer_mode,
    input  logic                         counting,
    input  logic                         display_update,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [sarct_pkg::KNOB_W-1:0] cfg_data,
    output int                           outstanding,
    output int                           fail_count
);
    import sarct_pkg::*;

    localparam logic [PROD_W-1:0] SEC_DIVISOR = 18'd1024;

    typedef struct packed {
        logic [TIME_W-1:0] minutes;
        logic [TIME_W-1:0] seconds;
        mode_t             mode;
        logic              counting;
        logic              refresh;
    } display_t;

    display_t          pending_displays[$];
    display_t          want;
    logic [KNOB_W-1:0] jitter_limit;
    mode_t             mode_now;
    logic [TIME_W-1:0] mins_now;
    logic [TIME_W-1:0] secs_now;
    logic              run_now;
    logic              last_button;
    logic [KNOB_W-1:0] last_knob;
    int                mismatches;

    // One tick: button edge, then knob, then the countdown step.
    function automatic display_t advance_one_second(input logic btn,
                                                    input logic [KNOB_W-1:0] knob);
        display_t          shown;
        logic [KNOB_W-1:0] delta;
        logic [PROD_W-1:0] scaled;
        logic              refresh;
        refresh = 1'b0;
        if (btn && !last_button)
        begin
            case (mode_now)
                MODE_SET_MIN: mode_now = MODE_SET_SEC;
                MODE_SET_SEC:
                begin
                    mode_now = MODE_RUN;
                    run_now  = 1'b1;
                end
                default: run_now = !run_now;
            endcase
            refresh = 1'b1;
        end
        delta = (knob >= last_knob) ? knob - last_knob : last_knob - knob;
        if (delta > jitter_limit)
        begin
            scaled = PROD_W'(knob) * KNOB_SCALE;
            if (mode_now == MODE_SET_MIN)
                mins_now = TIME_W'(scaled / MIN_DIVISOR);
            else if (mode_now == MODE_SET_SEC)
                secs_now = (scaled / SEC_DIVISOR > SEC_LIMIT) ? TIME_W'(SEC_LIMIT)
                                                              : TIME_W'(scaled / SEC_DIVISOR);
            last_knob = knob;
            refresh   = 1'b1;
        end
        if (run_now)
        begin
            if (secs_now != '0)
                secs_now = secs_now - 1'b1;
            else if (mins_now != '0)
            begin
                mins_now = mins_now - 1'b1;
                secs_now = SEC_WRAP;
            end
            else
            begin
                run_now  = 1'b0;
                mode_now = MODE_SET_MIN;
            end
            refresh = 1'b1;
        end
        last_button    = btn;
        shown.minutes  = mins_now;
        shown.seconds  = secs_now;
        shown.mode     = mode_now;
        shown.counting = run_now;
        shown.refresh  = refresh;
        return shown;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_limit = JITTER_RESET;
            mode_now     = MODE_SET_MIN;
            mins_now     = '0;
            secs_now     = '0;
            run_now      = 1'b0;
            last_button  = 1'b1;
            last_knob    = '0;
            mismatches   = 0;
            pending_displays.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                jitter_limit = cfg_data;
            if (out_valid && out_ready)
            begin
                if (pending_displays.size() == 0)
                begin
                    $error("result beat with no tick waiting");
                    mismatches++;
                end
                else
                begin
                    want = pending_displays.pop_front();
                    if (minutes_left !== want.minutes)
                    begin
                        $error("minutes_left expected %0d actual %0d", want.minutes, minutes_left);
                        mismatches++;
                    end
                    if (seconds_left !== want.seconds)
                    begin
                        $error("seconds_left expected %0d actual %0d", want.seconds, seconds_left);
                        mismatches++;
                    end
                    if (timer_mode !== want.mode)
                    begin
                        $error("timer_mode expected %0d actual %0d", want.mode, timer_mode);
                        mismatches++;
                    end
                    if (counting !== want.counting)
                    begin
                        $error("counting expected %0d actual %0d", want.counting, counting);
                        mismatches++;
                    end
                    if (display_update !== want.refresh)
                    begin
                        $error("display_update expected %0d actual %0d",
                               want.refresh, display_update);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                pending_displays.push_back(advance_one_second(button_level, knob_sample));
            outstanding <= pending_displays.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ===== verif/set_and_run_countdown_timer_top_tb.sv =====
// Testbench top for the countdown timer: drives ticks and threshold writes, gives the verdict.
`timescale 1ns / 1ps

module set_and_run_countdown_timer_top_tb;
    import sarct_pkg::*;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic              button_level   = 1'b0;
    logic [KNOB_W-1:0] knob_sample    = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [TIME_W-1:0] minutes_left;
    logic [TIME_W-1:0] seconds_left;
    logic [MODE_W-1:0] timer_mode;
    logic              counting;
    logic              display_update;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [KNOB_W-1:0] cfg_data       = '0;

    int outstanding;
    int fail_count;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int sent_items    = 0;

    set_and_run_countdown_timer_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_level   (button_level),
        .knob_sample    (knob_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .minutes_left   (minutes_left),
        .seconds_left   (seconds_left),
        .timer_mode     (timer_mode),
        .counting       (counting),
        .display_update (display_update),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    set_and_run_countdown_timer_checker timer_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_level   (button_level),
        .knob_sample    (knob_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .minutes_left   (minutes_left),
        .seconds_left   (seconds_left),
        .timer_mode     (timer_mode),
        .counting       (counting),
        .display_update (display_update),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .fail_count     (fail_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_tick(input logic btn, input logic [KNOB_W-1:0] knob);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        button_level <= btn;
        knob_sample  <= knob;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [KNOB_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Set minutes, set seconds, run for a while with the odd pause press and knob wobble.
    task automatic run_timer_session();
        logic [KNOB_W-1:0] min_knob;
        logic [KNOB_W-1:0] sec_knob;
        logic [KNOB_W-1:0] knob_now;
        logic              level;
        int                run_ticks;
        min_knob = ($urandom_range(9) < 8) ? KNOB_W'($urandom_range(140)) : KNOB_W'($urandom);
        sec_knob = ($urandom_range(9) < 8) ? KNOB_W'($urandom_range(400)) : KNOB_W'($urandom);
        send_tick(1'b0, min_knob ^ 12'h800);
        send_tick(1'b0, min_knob);
        send_tick(1'b1, min_knob);
        send_tick(1'b0, sec_knob ^ 12'h800);
        send_tick(1'b0, sec_knob);
        send_tick(1'b1, sec_knob);
        run_ticks = $urandom_range(60);
        repeat (run_ticks)
        begin
            level    = ($urandom_range(99) < 8);
            knob_now = ($urandom_range(99) < 15) ? KNOB_W'(sec_knob + $urandom_range(120))
                                                 : sec_knob;
            send_tick(level, knob_now);
        end
    endtask

    initial
    begin
        logic [KNOB_W-1:0] threshold;
        int                goal;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation, sixty seconds, expiry, pause, knob while running
        send_tick(1'b1, 12'd4095);
        send_tick(1'b0, 12'd0);
        send_tick(1'b1, 12'd2048);
        send_tick(1'b0, 12'd34);
        send_tick(1'b1, 12'd34);
        send_tick(1'b0, 12'd34);
        send_tick(1'b0, 12'd4095);
        send_tick(1'b1, 12'd4095);
        send_tick(1'b0, 12'd1040);
        send_tick(1'b1, 12'd1040);
        send_tick(1'b0, 12'd0);
        send_tick(1'b1, 12'd0);
        send_tick(1'b0, 12'd0);
        send_tick(1'b1, 12'd0);
        send_tick(1'b1, 12'd0);
        send_tick(1'b0, 12'd4095);
        send_tick(1'b0, 12'd4045);
        send_tick(1'b0, 12'd3994);

        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default:
                begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            case (p)
                0: threshold = 12'd0;
                1: threshold = 12'd4095;
                2: threshold = JITTER_RESET;
                3: threshold = 12'd1;
                5: threshold = 12'd2048;
                7: threshold = 12'd4094;
                default: threshold = KNOB_W'($urandom_range(300));
            endcase
            write_threshold(threshold);
            goal = sent_items + 220;
            while (sent_items < goal)
            begin
                if ($urandom_range(99) < 20)
                    repeat ($urandom_range(20, 1))
                        send_tick(1'($urandom), KNOB_W'($urandom));
                else
                    run_timer_session();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
